### design/lbt_pkg.sv
// shared types and constants of the lorentz boost transform unit
package lbt_pkg;

   localparam int VEL_W = 21;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      REG_VEL_X = 2'd0,
      REG_VEL_Y = 2'd1,
      REG_VEL_Z = 2'd2
   } reg_index_type;

   // matrix indexed [row][col], entries two's complement
   typedef logic [3:0][3:0][DATA_W-1:0] matrix_type;
   typedef logic [3:0][DATA_W-1:0] vec_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } lane_result_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_t;
      logic [DATA_W-1:0] out_x;
      logic [DATA_W-1:0] out_y;
      logic [DATA_W-1:0] out_z;
      logic              saturated;
   } rsp_word_type;

   // upper triangle of the spatial block, (row, col) in velocity indexes
   localparam int NUM_SPATIAL = 6;
   localparam logic [1:0] ENTRY_ROW [NUM_SPATIAL] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] ENTRY_COL [NUM_SPATIAL] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

endpackage

### design/lbt_req_if.sv
// request channel of the lorentz boost transform unit
interface lbt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_t;
   logic [31:0] in_x;
   logic [31:0] in_y;
   logic [31:0] in_z;

   modport source (output valid, output in_t, output in_x, output in_y, output in_z,
                   input ready);
   modport sink (input valid, input in_t, input in_x, input in_y, input in_z,
                 output ready);
endinterface

### design/lbt_rsp_if.sv
// response channel of the lorentz boost transform unit
interface lbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_t;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic        saturated;

   modport source (output valid, output out_t, output out_x, output out_y, output out_z,
                   output saturated, input ready);
   modport sink (input valid, input out_t, input out_x, input out_y, input out_z,
                 input saturated, output ready);
endinterface

### design/lbt_builder.sv
// sequential boost matrix builder with shared square root and fraction divider
module lbt_builder #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][20:0]      vel,
   output logic                  busy,
   output lbt_pkg::matrix_type   matrix
);

   localparam int RW = 2 * lbt_pkg::VEL_W + 2;
   localparam int SW = ((2 * FRAC_BITS > 2 * lbt_pkg::VEL_W) ?
                        2 * FRAC_BITS : 2 * lbt_pkg::VEL_W) + 2;
   localparam int QW = FRAC_BITS + 1;
   localparam int PW = lbt_pkg::DATA_W + QW;
   localparam int CW = $clog2(SW) + 1;
   localparam int PRW = 2 * lbt_pkg::VEL_W;
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQUARE = 7'b0000010,
      ST_SEED   = 7'b0000100,
      ST_SQRT   = 7'b0001000,
      ST_EDGE   = 7'b0010000,
      ST_LOAD   = 7'b0100000,
      ST_DIV    = 7'b1000000
   } state_type;
   // multiply and write-back share the step after the last divide
   localparam state_type ST_MUL_MARK = ST_IDLE;

   state_type               state_ff, state_in;
   logic                    mul_ff, mul_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [2:0]              ent_ff, ent_in;
   logic [RW-1:0]           r_ff, r_in;
   logic [SW-1:0]           n_ff, n_in;
   logic [SW-1:0]           res_ff, res_in;
   logic [SW-1:0]           bit_ff, bit_in;
   logic [31:0]             d_ff, d_in;
   logic [QW-1:0]           q_ff, q_in;
   logic [RW-1:0]           rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   lbt_pkg::matrix_type     matrix_ff, matrix_in;

   function automatic lbt_pkg::matrix_type identity();
      lbt_pkg::matrix_type m;
      m = '0;
      for (int k = 0; k < 4; k++) begin
         m[k][k] = ONE;
      end
      return m;
   endfunction

   logic signed [PRW-1:0]   sq;
   logic signed [PRW-1:0]   pr;
   logic [PRW-1:0]          mag;
   logic [SW-1:0]           trial;
   logic [RW-1:0]           rem2;
   logic [PW-1:0]           prodw;
   logic [PW-1:0]           rounded;
   logic [31:0]             p;
   logic [1:0]              ei;
   logic [1:0]              ej;

   always_comb begin
      state_in  = state_ff;
      mul_in    = mul_ff;
      cnt_in    = cnt_ff;
      ent_in    = ent_ff;
      r_in      = r_ff;
      n_in      = n_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      matrix_in = matrix_ff;

      ei      = lbt_pkg::ENTRY_ROW[ent_ff];
      ej      = lbt_pkg::ENTRY_COL[ent_ff];
      sq      = $signed(vel[cnt_ff[1:0]]) * $signed(vel[cnt_ff[1:0]]);
      pr      = $signed(vel[ei]) * $signed(vel[ej]);
      mag     = pr[PRW-1] ? PRW'(-pr) : PRW'(pr);
      trial   = res_ff + bit_ff;
      rem2    = {rem_ff[RW-2:0], 1'b0};
      prodw   = PW'(d_ff) * PW'(q_ff);
      rounded = (prodw + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      p       = neg_ff ? -rounded[31:0] : rounded[31:0];
      if (ei == ej) begin
         p = p + ONE;
      end

      if (mul_ff) begin
         // write the rounded spatial term into both symmetric places
         matrix_in[ei + 2'd1][ej + 2'd1] = p;
         matrix_in[ej + 2'd1][ei + 2'd1] = p;
         mul_in = 1'b0;
         if (ent_ff == 3'(lbt_pkg::NUM_SPATIAL - 1)) begin
            state_in = ST_IDLE;
         end else begin
            ent_in   = ent_ff + 3'd1;
            state_in = ST_LOAD;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_SQUARE: begin
               r_in   = r_ff + RW'(unsigned'(sq));
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(2)) begin
                  state_in = ST_SEED;
               end
            end
            ST_SEED: begin
               if (r_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  n_in     = (SW'(1) << (2 * FRAC_BITS)) + SW'(r_ff);
                  res_in   = '0;
                  bit_in   = SW'(1) << (SW - 2);
                  cnt_in   = '0;
                  state_in = ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (n_ff >= trial) begin
                  n_in   = n_ff - trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(SW / 2 - 1)) begin
                  state_in = ST_EDGE;
               end
            end
            ST_EDGE: begin
               d_in = res_ff[31:0] - ONE;
               matrix_in[0][0] = res_ff[31:0];
               for (int k = 0; k < 3; k++) begin
                  matrix_in[0][k+1] = -(32'(signed'(vel[k])));
                  matrix_in[k+1][0] = -(32'(signed'(vel[k])));
               end
               ent_in   = '0;
               state_in = ST_LOAD;
            end
            ST_LOAD: begin
               // magnitude never exceeds r, so the integer quotient is one bit
               if (RW'(mag) >= r_ff) begin
                  q_in   = QW'(1);
                  rem_in = RW'(mag) - r_ff;
               end else begin
                  q_in   = '0;
                  rem_in = RW'(mag);
               end
               neg_in   = vel[ei][20] ^ vel[ej][20];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
            ST_DIV: begin
               if (rem2 >= r_ff) begin
                  rem_in = rem2 - r_ff;
                  q_in   = {q_ff[QW-2:0], 1'b1};
               end else begin
                  rem_in = rem2;
                  q_in   = {q_ff[QW-2:0], 1'b0};
               end
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(FRAC_BITS - 1)) begin
                  mul_in   = 1'b1;
                  state_in = ST_MUL_MARK;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end

      if (start) begin
         state_in  = ST_SQUARE;
         mul_in    = 1'b0;
         cnt_in    = '0;
         r_in      = '0;
         matrix_in = identity();
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mul_ff    <= 1'b0;
         cnt_ff    <= '0;
         ent_ff    <= '0;
         matrix_ff <= identity();
      end else begin
         state_ff  <= state_in;
         mul_ff    <= mul_in;
         cnt_ff    <= cnt_in;
         ent_ff    <= ent_in;
         matrix_ff <= matrix_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign busy   = (state_ff != ST_IDLE) || mul_ff;
   assign matrix = matrix_ff;

endmodule

### design/lbt_lane.sv
// one matrix row times the vector, rounded and saturated, three stages
module lbt_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  lbt_pkg::vec_type         row,
   input  lbt_pkg::vec_type         vec,
   output lbt_pkg::lane_result_type result
);

   localparam int SUMW = 67;

   logic signed [63:0]      prod_ff [4];
   logic signed [64:0]      pair_ff [2];
   lbt_pkg::lane_result_type result_ff, result_in;

   logic signed [SUMW-1:0]  total;
   logic signed [SUMW-1:0]  shifted;

   always_comb begin
      total   = SUMW'(pair_ff[0]) + SUMW'(pair_ff[1]) + (SUMW'(1) << (FRAC_BITS - 1));
      shifted = total >>> FRAC_BITS;
      if (shifted[SUMW-1:31] != {(SUMW - 31){shifted[31]}}) begin
         result_in.sat   = 1'b1;
         result_in.value = shifted[SUMW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         result_in.sat   = 1'b0;
         result_in.value = shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed(row[k]) * $signed(vec[k]);
         end
         pair_ff[0] <= 65'(prod_ff[0]) + 65'(prod_ff[1]);
         pair_ff[1] <= 65'(prod_ff[2]) + 65'(prod_ff[3]);
         result_ff  <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### design/lbt_merge.sv
// merges lane results into the response register and derives the pipeline advance
module lbt_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  lbt_pkg::lane_result_type [3:0] lanes,
   input  logic                          out_ready,
   output logic                          en,
   output logic                          out_valid,
   output lbt_pkg::rsp_word_type         out_word
);

   logic                  valid_ff;
   lbt_pkg::rsp_word_type word_ff, word_in;

   assign en = !valid_ff || out_ready;

   always_comb begin
      word_in.out_t     = lanes[0].value;
      word_in.out_x     = lanes[1].value;
      word_in.out_y     = lanes[2].value;
      word_in.out_z     = lanes[3].value;
      word_in.saturated = lanes[0].sat | lanes[1].sat | lanes[2].sat | lanes[3].sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### design/lorentz_boost_transform_unit.sv
// lorentz boost transform unit: four row lanes against a rebuilt boost matrix
// a request passes 3 lane stages and then the merge register before its response is valid
// throughput: one request per cycle on four 4-multiplier lanes, unless busy or stalled
// config write: matrix rebuild holds req ready low while it sums squares, takes the root,
//   fills edge row and column, divides out 6 spatial entries; zero speed keeps identity
// reset: synchronous, velocity cleared, matrix set to identity, pipeline emptied
module lorentz_boost_transform_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   lbt_req_if.sink      req_chan,
   lbt_rsp_if.source    rsp_chan,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // velocity registers, signed q4.16 at the default fraction width
   logic [2:0][20:0]     vel_ff, vel_in;
   logic                 start;
   logic                 busy;
   lbt_pkg::matrix_type  matrix;

   // pipeline control
   logic                 en;
   logic                 accept;
   logic [2:0]           valid_ff;
   lbt_pkg::vec_type     vec;
   lbt_pkg::lane_result_type [3:0] lanes;
   lbt_pkg::rsp_word_type rsp_word;
   logic                 rsp_valid;

   assign csr_pready = 1'b1;

   // velocity register writes land at the access phase and kick off a rebuild
   always_comb begin
      vel_in = vel_ff;
      start  = 1'b0;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            lbt_pkg::REG_VEL_X, lbt_pkg::REG_VEL_Y, lbt_pkg::REG_VEL_Z: begin
               vel_in[csr_paddr[3:2]] = csr_pwdata[20:0];
               start = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
      end else begin
         vel_ff <= vel_in;
      end
   end

   // reads return the velocity sign extended
   always_comb begin
      case (csr_paddr[3:2])
         lbt_pkg::REG_VEL_X, lbt_pkg::REG_VEL_Y, lbt_pkg::REG_VEL_Z: begin
            csr_prdata = 32'(signed'(vel_ff[csr_paddr[3:2]]));
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   lbt_builder #(.FRAC_BITS(FRAC_BITS)) u_builder (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .vel    (vel_ff),
      .busy   (busy),
      .matrix (matrix)
   );

   // the whole pipeline advances together whenever the response register can move
   assign req_chan.ready = en && !busy;
   assign accept         = req_chan.valid && req_chan.ready;

   assign vec[0] = req_chan.in_t;
   assign vec[1] = req_chan.in_x;
   assign vec[2] = req_chan.in_y;
   assign vec[3] = req_chan.in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], accept};
      end
   end

   // one lane per output component
   for (genvar g = 0; g < 4; g++) begin : g_lane
      lbt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .en     (en),
         .row    (matrix[g]),
         .vec    (vec),
         .result (lanes[g])
      );
   end

   lbt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[2]),
      .lanes     (lanes),
      .out_ready (rsp_chan.ready),
      .en        (en),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   assign rsp_chan.valid     = rsp_valid;
   assign rsp_chan.out_t     = rsp_word.out_t;
   assign rsp_chan.out_x     = rsp_word.out_x;
   assign rsp_chan.out_y     = rsp_word.out_y;
   assign rsp_chan.out_z     = rsp_word.out_z;
   assign rsp_chan.saturated = rsp_word.saturated;

endmodule

### design/lbt_checker.sv
// port-level checks of the lorentz boost transform unit and their binding
module lbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] out_t,
   input logic [31:0] out_x,
   input logic [31:0] out_y,
   input logic [31:0] out_z,
   input logic        saturated,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr
);

   function automatic logic at_limit(logic [31:0] v);
      return (v == 32'h7fff_ffff) || (v == 32'h8000_0000);
   endfunction

   // a velocity write starts a rebuild, so no request is taken next cycle
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && (csr_paddr[3:2] != 2'd3)) |=> !req_ready)
      else $error("request taken right after a velocity write");

   // a flagged response carries at least one clipped component
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && saturated) |->
         (at_limit(out_t) || at_limit(out_x) || at_limit(out_y) || at_limit(out_z)))
      else $error("saturated flag without a clipped component");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind lorentz_boost_transform_unit lbt_checker u_lbt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_t       (rsp_chan.out_t),
   .out_x       (rsp_chan.out_x),
   .out_y       (rsp_chan.out_y),
   .out_z       (rsp_chan.out_z),
   .saturated   (rsp_chan.saturated),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr)
);
